// ----- design/ospd_pkg.sv -----
package ospd_pkg;

    // input item
    typedef struct packed {
        logic [7:0] code_byte;
        logic       new_run;
    } in_item_t;

    // decoded instruction record
    typedef struct packed {
        logic [15:0] instr_address;
        logic [7:0]  opcode;
        logic [6:0]  mnemonic;
        logic [3:0]  addr_mode;
        logic [1:0]  length;
        logic [15:0] operand;
        logic [15:0] branch_target;
        logic        has_target;
    } out_item_t;

    // byte position within the instruction being gathered
    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2
    } phase_t;

    localparam logic [3:0] MODE_REL    = 4'd5;
    localparam logic [3:0] MODE_ZP_REL = 4'd14;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // addressing mode per opcode
    localparam logic [3:0] MODE_TAB [256] = '{
        4'd4, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd3, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd13, 4'd0, 4'd2, 4'd9, 4'd9, 4'd14,
        4'd2, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd7, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd13, 4'd0, 4'd9, 4'd9, 4'd9, 4'd14,
        4'd4, 4'd11, 4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd0, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd0, 4'd9, 4'd9, 4'd14,
        4'd4, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd6, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd7, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd9, 4'd9, 4'd9, 4'd14,
        4'd5, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd7, 4'd7, 4'd8, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd2, 4'd9, 4'd9, 4'd14,
        4'd1, 4'd11, 4'd1, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd7, 4'd7, 4'd8, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd9, 4'd9, 4'd10, 4'd14,
        4'd1, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd0, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd0, 4'd9, 4'd9, 4'd14,
        4'd1, 4'd11, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd1, 4'd4, 4'd0, 4'd2, 4'd2, 4'd2, 4'd14,
        4'd5, 4'd12, 4'd0, 4'd0, 4'd0, 4'd7, 4'd7, 4'd3,
        4'd4, 4'd10, 4'd4, 4'd0, 4'd0, 4'd9, 4'd9, 4'd14
    };

    // mnemonic number per opcode
    localparam logic [6:0] MNEM_TAB [256] = '{
        7'd48, 7'd26, 7'd0, 7'd0, 7'd63, 7'd26, 7'd28, 7'd81,
        7'd14, 7'd26, 7'd28, 7'd0, 7'd63, 7'd26, 7'd28, 7'd65,
        7'd41, 7'd26, 7'd0, 7'd0, 7'd64, 7'd26, 7'd28, 7'd82,
        7'd50, 7'd26, 7'd19, 7'd0, 7'd64, 7'd26, 7'd28, 7'd66,
        7'd45, 7'd25, 7'd0, 7'd0, 7'd35, 7'd25, 7'd30, 7'd83,
        7'd16, 7'd25, 7'd30, 7'd0, 7'd35, 7'd25, 7'd30, 7'd67,
        7'd39, 7'd25, 7'd0, 7'd0, 7'd35, 7'd25, 7'd30, 7'd84,
        7'd54, 7'd25, 7'd22, 7'd0, 7'd35, 7'd25, 7'd30, 7'd68,
        7'd47, 7'd27, 7'd0, 7'd0, 7'd0, 7'd27, 7'd29, 7'd85,
        7'd13, 7'd27, 7'd29, 7'd0, 7'd44, 7'd27, 7'd29, 7'd69,
        7'd42, 7'd27, 7'd0, 7'd0, 7'd0, 7'd27, 7'd29, 7'd86,
        7'd52, 7'd27, 7'd58, 7'd0, 7'd0, 7'd27, 7'd29, 7'd70,
        7'd46, 7'd17, 7'd0, 7'd0, 7'd62, 7'd17, 7'd31, 7'd87,
        7'd15, 7'd17, 7'd31, 7'd0, 7'd44, 7'd17, 7'd31, 7'd71,
        7'd43, 7'd17, 7'd0, 7'd0, 7'd62, 7'd17, 7'd31, 7'd88,
        7'd56, 7'd17, 7'd59, 7'd0, 7'd44, 7'd17, 7'd31, 7'd72,
        7'd57, 7'd4, 7'd0, 7'd0, 7'd6, 7'd4, 7'd5, 7'd89,
        7'd24, 7'd35, 7'd10, 7'd0, 7'd6, 7'd4, 7'd5, 7'd73,
        7'd36, 7'd4, 7'd0, 7'd0, 7'd6, 7'd4, 7'd5, 7'd90,
        7'd12, 7'd4, 7'd11, 7'd0, 7'd62, 7'd4, 7'd62, 7'd74,
        7'd3, 7'd1, 7'd2, 7'd0, 7'd3, 7'd1, 7'd2, 7'd91,
        7'd8, 7'd1, 7'd7, 7'd0, 7'd3, 7'd1, 7'd2, 7'd75,
        7'd37, 7'd1, 7'd0, 7'd0, 7'd3, 7'd1, 7'd2, 7'd92,
        7'd53, 7'd1, 7'd9, 7'd0, 7'd3, 7'd1, 7'd2, 7'd76,
        7'd34, 7'd32, 7'd0, 7'd0, 7'd34, 7'd32, 7'd22, 7'd93,
        7'd21, 7'd32, 7'd23, 7'd0, 7'd34, 7'd32, 7'd22, 7'd77,
        7'd40, 7'd32, 7'd0, 7'd0, 7'd0, 7'd32, 7'd22, 7'd94,
        7'd51, 7'd32, 7'd60, 7'd0, 7'd0, 7'd32, 7'd22, 7'd78,
        7'd33, 7'd18, 7'd0, 7'd0, 7'd33, 7'd18, 7'd19, 7'd95,
        7'd20, 7'd18, 7'd49, 7'd0, 7'd33, 7'd18, 7'd19, 7'd79,
        7'd38, 7'd18, 7'd0, 7'd0, 7'd0, 7'd18, 7'd19, 7'd96,
        7'd55, 7'd18, 7'd61, 7'd0, 7'd0, 7'd18, 7'd19, 7'd80
    };

    // instruction length from addressing mode
    function automatic logic [1:0] mode_len(input logic [3:0] mode);
        logic [1:0] len;
        case (mode) inside
            4'd0, 4'd4, 4'd13, 4'd15: len = LEN_ONE;
            4'd2, 4'd6, 4'd9, 4'd10, 4'd14: len = LEN_THREE;
            default: len = LEN_TWO;
        endcase
        return len;
    endfunction

endpackage

// ----- design/ospd_assemble.sv -----
module ospd_assemble (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  ospd_pkg::in_item_t   item,
    input  logic [15:0]          base_address,
    output logic                 emit,
    output ospd_pkg::out_item_t  rec
);

    ospd_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [7:0]  held_opcode_reg, held_opcode_next;
    logic [7:0]  held_low_reg, held_low_next;
    logic [15:0] byte_addr_reg, byte_addr_next;
    logic [15:0] start_addr_reg, start_addr_next;

    logic [15:0] addr_cur;
    logic        is_opcode;
    logic [7:0]  op_sel;
    logic [15:0] start_sel;
    logic [3:0]  mode_sel;
    logic [1:0]  len_sel;
    logic [15:0] operand;
    logic [15:0] disp;
    logic        has_target;

    always_comb begin
        phase_cur = item.new_run ? ospd_pkg::PH_OPCODE : phase_reg;
        addr_cur  = item.new_run ? base_address : byte_addr_reg;
        case (phase_cur)
            ospd_pkg::PH_LOW, ospd_pkg::PH_HIGH: is_opcode = 1'b0;
            default: is_opcode = 1'b1;
        endcase
        op_sel    = is_opcode ? item.code_byte : held_opcode_reg;
        start_sel = is_opcode ? addr_cur : start_addr_reg;
        mode_sel  = ospd_pkg::MODE_TAB[op_sel];
        len_sel   = ospd_pkg::mode_len(mode_sel);

        emit             = 1'b0;
        operand          = 16'h0000;
        phase_next       = ospd_pkg::PH_OPCODE;
        held_opcode_next = held_opcode_reg;
        held_low_next    = held_low_reg;
        start_addr_next  = start_addr_reg;
        byte_addr_next   = addr_cur + 16'd1;

        case (phase_cur)
            ospd_pkg::PH_LOW: begin
                if (len_sel == ospd_pkg::LEN_TWO) begin
                    emit    = 1'b1;
                    operand = {8'h00, item.code_byte};
                end else begin
                    held_low_next = item.code_byte;
                    phase_next    = ospd_pkg::PH_HIGH;
                end
            end
            ospd_pkg::PH_HIGH: begin
                emit    = 1'b1;
                operand = {item.code_byte, held_low_reg};
            end
            default: begin
                held_opcode_next = item.code_byte;
                start_addr_next  = addr_cur;
                if (len_sel == ospd_pkg::LEN_ONE) begin
                    emit = 1'b1;
                end else begin
                    phase_next = ospd_pkg::PH_LOW;
                end
            end
        endcase

        // branch displacement, zp-relative uses the high operand byte
        has_target = (mode_sel == ospd_pkg::MODE_REL) || (mode_sel == ospd_pkg::MODE_ZP_REL);
        if (mode_sel == ospd_pkg::MODE_ZP_REL) begin
            disp = {{8{operand[15]}}, operand[15:8]} + 16'd3;
        end else begin
            disp = {{8{operand[7]}}, operand[7:0]} + 16'd2;
        end

        rec.instr_address = start_sel;
        rec.opcode        = op_sel;
        rec.mnemonic      = ospd_pkg::MNEM_TAB[op_sel];
        rec.addr_mode     = mode_sel;
        rec.length        = len_sel;
        rec.operand       = operand;
        rec.branch_target = has_target ? (start_sel + disp) : 16'h0000;
        rec.has_target    = has_target;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ospd_pkg::PH_OPCODE;
            held_opcode_reg <= 8'h00;
            held_low_reg    <= 8'h00;
            byte_addr_reg   <= 16'h0000;
            start_addr_reg  <= 16'h0000;
        end else if (step) begin
            phase_reg       <= phase_next;
            held_opcode_reg <= held_opcode_next;
            held_low_reg    <= held_low_next;
            byte_addr_reg   <= byte_addr_next;
            start_addr_reg  <= start_addr_next;
        end
    end

    a_emit_ends_instr: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit |=> phase_reg == ospd_pkg::PH_OPCODE)
        else $error("phase not back to opcode after a record");

    a_addr_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.new_run |=> byte_addr_reg == $past(byte_addr_reg) + 16'd1)
        else $error("byte address did not advance by one");

endmodule

// ----- design/ospd_out_stage.sv -----
module ospd_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  ospd_pkg::out_item_t  rec_in,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ospd_pkg::out_item_t  m_item
);

    logic                valid_reg, valid_next;
    ospd_pkg::out_item_t item_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_comb begin
        valid_next = load || (valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= rec_in;
        end
    end

    a_len_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> item_reg.length == ospd_pkg::mode_len(item_reg.addr_mode))
        else $error("record length disagrees with its mode");

    a_no_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !item_reg.has_target |-> item_reg.branch_target == 16'h0000)
        else $error("branch target set without a relative mode");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !load)
        else $error("record loaded over an untaken one");

endmodule

// ----- design/opcode_stream_predecoder_top.sv -----
// path: the last byte of an instruction waits in the input register, and its record
//   then goes into the result register that drives m_valid once that register is free
// throughput: one code byte and at most one record per cycle unless m_ready stalls,
//   limited by the single result register and the byte-serial input
// reset: aresetn low at a clock edge empties both registers, sets base_address to 0
//   and expects an opcode at address 0
module opcode_stream_predecoder_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // code byte stream
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ospd_pkg::in_item_t   s_item,
    // decoded instruction records
    output logic                 m_valid,
    input  logic                 m_ready,
    output ospd_pkg::out_item_t  m_item,
    // base_address register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    // input register
    logic               in_valid_reg, in_valid_next;
    ospd_pkg::in_item_t in_item_reg;

    // configuration
    logic [15:0] base_reg;

    // decode and result stage handshake
    logic                emit;
    logic                out_free;
    logic                advance;
    ospd_pkg::out_item_t rec;

    // the held item moves on when the result register can take its record,
    // or at once when the byte completes no instruction
    assign advance   = in_valid_reg && (out_free || !emit);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            base_reg     <= 16'h0000;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // opcode lookup, operand gathering and branch target
    ospd_assemble u_assemble (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (in_item_reg),
        .base_address (base_reg),
        .emit         (emit),
        .rec          (rec)
    );

    // result register
    ospd_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && emit),
        .rec_in  (rec),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    a_held_item_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled item lost from the input register");

endmodule

// ----- tb/sv/ospd_record_checker.sv -----
`timescale 1ns / 100ps
module ospd_record_checker
    import ospd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // {addressing mode, mnemonic} per opcode
    localparam int unsigned OPC_TABLE [512] = '{
        4,48, 11,26, 0,0, 0,0, 3,63, 3,26, 3,28, 3,81,
        4,14, 1,26, 4,28, 0,0, 2,63, 2,26, 2,28, 14,65,
        5,41, 12,26, 0,0, 0,0, 3,64, 7,26, 7,28, 3,82,
        4,50, 10,26, 13,19, 0,0, 2,64, 9,26, 9,28, 14,66,
        2,45, 11,25, 0,0, 0,0, 3,35, 3,25, 3,30, 3,83,
        4,16, 1,25, 4,30, 0,0, 2,35, 2,25, 2,30, 14,67,
        5,39, 12,25, 0,0, 0,0, 7,35, 7,25, 7,30, 3,84,
        4,54, 10,25, 13,22, 0,0, 9,35, 9,25, 9,30, 14,68,
        4,47, 11,27, 0,0, 0,0, 0,0, 3,27, 3,29, 3,85,
        4,13, 1,27, 4,29, 0,0, 2,44, 2,27, 2,29, 14,69,
        5,42, 12,27, 0,0, 0,0, 0,0, 7,27, 7,29, 3,86,
        4,52, 10,27, 4,58, 0,0, 0,0, 9,27, 9,29, 14,70,
        4,46, 11,17, 0,0, 0,0, 3,62, 3,17, 3,31, 3,87,
        4,15, 1,17, 4,31, 0,0, 6,44, 2,17, 2,31, 14,71,
        5,43, 12,17, 0,0, 0,0, 7,62, 7,17, 7,31, 3,88,
        4,56, 10,17, 4,59, 0,0, 9,44, 9,17, 9,31, 14,72,
        5,57, 11,4, 0,0, 0,0, 3,6, 3,4, 3,5, 3,89,
        4,24, 1,35, 4,10, 0,0, 2,6, 2,4, 2,5, 14,73,
        5,36, 12,4, 0,0, 0,0, 7,6, 7,4, 8,5, 3,90,
        4,12, 10,4, 4,11, 0,0, 2,62, 9,4, 9,62, 14,74,
        1,3, 11,1, 1,2, 0,0, 3,3, 3,1, 3,2, 3,91,
        4,8, 1,1, 4,7, 0,0, 2,3, 2,1, 2,2, 14,75,
        5,37, 12,1, 0,0, 0,0, 7,3, 7,1, 8,2, 3,92,
        4,53, 10,1, 4,9, 0,0, 9,3, 9,1, 10,2, 14,76,
        1,34, 11,32, 0,0, 0,0, 3,34, 3,32, 3,22, 3,93,
        4,21, 1,32, 4,23, 0,0, 2,34, 2,32, 2,22, 14,77,
        5,40, 12,32, 0,0, 0,0, 0,0, 7,32, 7,22, 3,94,
        4,51, 10,32, 4,60, 0,0, 0,0, 9,32, 9,22, 14,78,
        1,33, 11,18, 0,0, 0,0, 3,33, 3,18, 3,19, 3,95,
        4,20, 1,18, 4,49, 0,0, 2,33, 2,18, 2,19, 14,79,
        5,38, 12,18, 0,0, 0,0, 0,0, 7,18, 7,19, 3,96,
        4,55, 10,18, 4,61, 0,0, 0,0, 9,18, 9,19, 14,80
    };

    // bytes per instruction for each addressing mode
    localparam int unsigned MODE_BYTES [16] = '{1,2,3,2,1,2,3,2,2,3,3,2,2,1,3,1};

    logic [15:0] base_addr;
    phase_t      phase;
    logic [7:0]  held_op;
    logic [7:0]  low_byte;
    logic [15:0] next_addr;
    logic [15:0] instr_addr;
    out_item_t   expected_records [$];
    int          err_count = 0;
    int          queued = 0;

    assign mismatches  = err_count;
    assign outstanding = queued;

    function automatic logic [3:0] mode_of(input logic [7:0] op);
        return 4'(OPC_TABLE[2 * int'(op)]);
    endfunction

    // advance the decode state by one code byte; fires when an instruction completes
    function automatic void decode_byte(input logic [7:0] b, input logic restart,
                                        output logic fired, output out_item_t rec);
        logic [15:0] addr;
        logic [15:0] opnd;
        logic [3:0]  mode;
        fired = 1'b0;
        opnd  = '0;
        rec   = '0;
        if (restart) begin
            phase     = PH_OPCODE;
            next_addr = base_addr;
        end
        addr      = next_addr;
        next_addr = addr + 16'd1;
        case (phase)
            PH_LOW: begin
                if (MODE_BYTES[mode_of(held_op)] == 2) begin
                    phase = PH_OPCODE;
                    fired = 1'b1;
                    opnd  = {8'h00, b};
                end else begin
                    low_byte = b;
                    phase    = PH_HIGH;
                end
            end
            PH_HIGH: begin
                phase = PH_OPCODE;
                fired = 1'b1;
                opnd  = {b, low_byte};
            end
            default: begin
                held_op    = b;
                instr_addr = addr;
                if (MODE_BYTES[mode_of(b)] == 1) begin
                    phase = PH_OPCODE;
                    fired = 1'b1;
                end else begin
                    phase = PH_LOW;
                end
            end
        endcase
        if (fired) begin
            mode              = mode_of(held_op);
            rec.instr_address = instr_addr;
            rec.opcode        = held_op;
            rec.mnemonic      = 7'(OPC_TABLE[2 * int'(held_op) + 1]);
            rec.addr_mode     = mode;
            rec.length        = 2'(MODE_BYTES[mode]);
            rec.operand       = opnd;
            if (mode == MODE_REL) begin
                rec.branch_target = instr_addr + 16'd2 + {{8{opnd[7]}}, opnd[7:0]};
                rec.has_target    = 1'b1;
            end else if (mode == MODE_ZP_REL) begin
                rec.branch_target = instr_addr + 16'd3 + {{8{opnd[15]}}, opnd[15:8]};
                rec.has_target    = 1'b1;
            end
        end
    endfunction

    task automatic compare_record(input out_item_t exp_rec, input out_item_t got);
        if (got.instr_address !== exp_rec.instr_address) begin
            $error("instr_address: expected %h, got %h", exp_rec.instr_address,
                   got.instr_address);
            err_count++;
        end
        if (got.opcode !== exp_rec.opcode) begin
            $error("opcode: expected %h, got %h", exp_rec.opcode, got.opcode);
            err_count++;
        end
        if (got.mnemonic !== exp_rec.mnemonic) begin
            $error("mnemonic: expected %0d, got %0d", exp_rec.mnemonic, got.mnemonic);
            err_count++;
        end
        if (got.addr_mode !== exp_rec.addr_mode) begin
            $error("addr_mode: expected %0d, got %0d", exp_rec.addr_mode, got.addr_mode);
            err_count++;
        end
        if (got.length !== exp_rec.length) begin
            $error("length: expected %0d, got %0d", exp_rec.length, got.length);
            err_count++;
        end
        if (got.operand !== exp_rec.operand) begin
            $error("operand: expected %h, got %h", exp_rec.operand, got.operand);
            err_count++;
        end
        if (got.branch_target !== exp_rec.branch_target) begin
            $error("branch_target: expected %h, got %h", exp_rec.branch_target,
                   got.branch_target);
            err_count++;
        end
        if (got.has_target !== exp_rec.has_target) begin
            $error("has_target: expected %b, got %b", exp_rec.has_target, got.has_target);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t rec;
        logic      fired;
        if (!aresetn) begin
            base_addr  = '0;
            phase      = PH_OPCODE;
            held_op    = '0;
            low_byte   = '0;
            next_addr  = '0;
            instr_addr = '0;
            expected_records.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                base_addr = cfg_data;
            if (s_valid && s_ready) begin
                decode_byte(s_item.code_byte, s_item.new_run, fired, rec);
                if (fired)
                    expected_records.push_back(rec);
            end
            if (m_valid && m_ready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record: opcode %h at %h", m_item.opcode,
                           m_item.instr_address);
                    err_count++;
                end else begin
                    compare_record(expected_records.pop_front(), m_item);
                end
            end
        end
        queued <= expected_records.size();
    end

endmodule

// ----- tb/sv/opcode_stream_predecoder_top_tb.sv -----
`timescale 1ns / 100ps
module opcode_stream_predecoder_top_tb;
    import ospd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;   // long receiver stall, fills the pipeline
    localparam int DRAIN_GAP   = 4;     // covers the two-register latency
    localparam int IDLE_PCT    = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // knobs shared between the stimulus and the receiver
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    opcode_stream_predecoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts records and compares them
    ospd_record_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a lost record ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("opcode_stream_predecoder_top regression: fail");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= rx_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // offer one code byte, with random gaps in front, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic restart);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{code_byte: b, new_run: restart};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and let every expected record come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_base(input logic [15:0] addr);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed instructions with random content; some are cut short
    // or padded, with restarts landing on operand bytes
    task automatic send_random_instr(input bit force_restart);
        logic [7:0] op;
        int         operands;
        bit         broken;
        op       = 8'($urandom_range(255));
        operands = int'(mode_len(MODE_TAB[op])) - 1;
        broken   = ($urandom_range(99) < 10);
        if (broken)
            operands = $urandom_range(2);
        send_byte(op, force_restart || ($urandom_range(99) < 5));
        for (int k = 0; k < operands; k++)
            send_byte(8'($urandom_range(255)), broken && ($urandom_range(3) == 0));
    endtask

    initial begin
        logic [15:0] base;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // no restart after reset: decoding starts at address 0
        send_byte(8'hEA, 1'b0);             // one-byte implied
        send_byte(8'h4C, 1'b0);             // absolute jump, three bytes
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hD0, 1'b0);             // backward branch wraps below zero
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0);             // zero-page relative, forward extreme
        send_byte(8'h12, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h12, 1'b0);             // (zp) form is not listed: invalid
        send_byte(8'hFF, 1'b0);             // all-ones opcode and operands
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);             // all-zero opcode
        send_byte(8'h20, 1'b0);             // dropped by the restart that follows
        send_byte(8'hA9, 1'b1);
        send_byte(8'h00, 1'b0);

        // top of the address space: branch target and byte address both wrap
        settle();
        write_base(16'hFFFE);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h9C, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h11, 1'b0);

        // new base written mid-instruction only counts from the next restart
        settle();
        write_base(16'h1234);
        send_byte(8'h22, 1'b0);
        send_byte(8'h1A, 1'b1);

        // random phases over several bases; the second one carries the long
        // receiver hold-off, the third runs with no idling on either side
        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: base = 16'h0000;
                1: base = 16'hFFFF;
                3: base = 16'hFFF0;
                default: base = 16'($urandom);
            endcase
            write_base(base);
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < 50; i++)
                send_random_instr(i == 0);
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("opcode_stream_predecoder_top regression: pass");
        else
            $display("opcode_stream_predecoder_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ospd_pkg.sv
design/ospd_assemble.sv
design/ospd_out_stage.sv
design/opcode_stream_predecoder_top.sv
tb/sv/ospd_record_checker.sv
tb/sv/opcode_stream_predecoder_top_tb.sv
